[rtl/int64_to_decimal_text_top_macros.svh]
// ----------------------------------------------------------------------------
// int64_to_decimal_text_top_macros.svh
// Assertion helpers shared by the decimal text converter RTL.
// ----------------------------------------------------------------------------
`ifndef INT64_TO_DECIMAL_TEXT_TOP_MACROS_SVH
`define INT64_TO_DECIMAL_TEXT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2DT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("i2dt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2DT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("i2dt assertion failed");

`endif

[rtl/i2dt_pkg.sv]
// ----------------------------------------------------------------------------
// i2dt_pkg
// Types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package i2dt_pkg;

  localparam int unsigned VALUE_IN_W = 64;
  localparam int unsigned CAP_W      = 8;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned DIGIT_W    = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;

  typedef struct packed {
    logic signed [VALUE_IN_W-1:0] value;
    logic [CAP_W-1:0]             capacity;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              error;
    logic [LEN_W-1:0]  length;
  } out_item_t;

  // Converter status toward the control logic.
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] ndig;
  } conv_status_t;

endpackage

[rtl/i2dt_conv.sv]
// ----------------------------------------------------------------------------
// i2dt_conv
// Bit-serial binary to BCD converter (shift and add-3), leading zero
// strip, then digit pop from the most significant end.
// ----------------------------------------------------------------------------
`include "int64_to_decimal_text_top_macros.svh"

module i2dt_conv #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [VALUE_WIDTH-1:0]    mag_i,
  input  logic                      pop_i,
  output i2dt_pkg::conv_status_t    status_o,
  output logic [i2dt_pkg::DIGIT_W-1:0] digit_o
);
  import i2dt_pkg::*;

  localparam int unsigned NDIG  = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int unsigned BCD_W = NDIG * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DABBLE = 2'd1;
  localparam logic [1:0] PH_NORM   = 2'd2;
  localparam logic [1:0] PH_READY  = 2'd3;

  logic [1:0]             phase_q, phase_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0]       ndig_q, ndig_d;
  logic [DIGIT_W-1:0]     top_dig;

  assign top_dig = bcd_q[BCD_W-1 -: DIGIT_W];

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
          bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3 : bcd_q[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_comb begin
    phase_d = phase_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    if (start_i) begin
      phase_d = PH_DABBLE;
      mag_d   = mag_i;
      bcd_d   = '0;
      cnt_d   = CNT_W'(VALUE_WIDTH);
    end else begin
      case (phase_q)
        PH_DABBLE: begin
          bcd_d = {adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
          mag_d = mag_q << 1;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            phase_d = PH_NORM;
            ndig_d  = LEN_W'(NDIG);
          end
        end
        PH_NORM: begin
          // Drop leading zeros, keep at least one digit.
          if (top_dig == '0 && ndig_q > LEN_W'(1)) begin
            bcd_d  = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            ndig_d = ndig_q - 1'b1;
          end else begin
            phase_d = PH_READY;
          end
        end
        PH_READY: begin
          if (pop_i) begin
            bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      ndig_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ndig_q  <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign status_o.done = (phase_q == PH_READY);
  assign status_o.ndig = ndig_q;
  assign digit_o       = top_dig;

  `I2DT_ASSERT_SAME(a_start_when_free, clk_i, rst_ni, start_i,
      phase_q == PH_IDLE || phase_q == PH_READY)
  `I2DT_ASSERT_SAME(a_pop_when_ready, clk_i, rst_ni, pop_i, phase_q == PH_READY)
  `I2DT_ASSERT_SAME(a_ndig_nonzero, clk_i, rst_ni,
      phase_q == PH_NORM || phase_q == PH_READY,
      ndig_q != '0 && ndig_q <= LEN_W'(NDIG))

endmodule

[rtl/int64_to_decimal_text_top.sv]
// Sequence: after acceptance, the bit-serial shift/add-3 loop runs over every bit of the
//   magnitude, leading zeros are stripped, then the fit check; characters follow one per
//   cycle while the output is not stalled; an error item goes out straight from the check.
// Input: in_stall_o stays high from acceptance until the last character or the error item
//   is registered, so a new item is never taken while a conversion is in flight.
// Reset: asynchronous, active low; clears control state and output valid.
// ----------------------------------------------------------------------------
// int64_to_decimal_text_top
// Signed integer to ASCII decimal text, one character per output item.
// ----------------------------------------------------------------------------
`include "int64_to_decimal_text_top_macros.svh"

module int64_to_decimal_text_top #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  i2dt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2dt_pkg::out_item_t  out_item_o
);
  import i2dt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic                   neg_q, neg_d;
  logic                   sign_pend_q, sign_pend_d;
  logic [CAP_W-1:0]       cap_q, cap_d;
  logic [LEN_W-1:0]       total_q, total_d;
  logic [LEN_W-1:0]       left_q, left_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   pop;
  logic [LEN_W-1:0]       total;
  conv_status_t           conv_st;
  logic [DIGIT_W-1:0]     digit;

  // Take a new item only when no conversion is in flight; the output
  // register may still hold the previous item's last character.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Low VALUE_WIDTH bits as two's complement; the most negative value
  // maps to 2^(VALUE_WIDTH-1), which still fits unsigned.
  assign raw = in_item_i.value[VALUE_WIDTH-1:0];
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  assign total = conv_st.ndig + LEN_W'(neg_q);

  i2dt_conv #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .mag_i   (mag),
    .pop_i   (pop),
    .status_o(conv_st),
    .digit_o (digit)
  );

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    cap_d       = cap_q;
    total_d     = total_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    pop         = 1'b0;

    // Drop the held item once it has been taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          neg_d   = raw[VALUE_WIDTH-1];
          cap_d   = in_item_i.capacity;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_st.done) begin
          if ({{(CAP_W-LEN_W){1'b0}}, total} > cap_q) begin
            // Text does not fit: one error item, nothing else.
            if (out_free) begin
              out_valid_d          = 1'b1;
              out_item_d.character = CHAR_NONE;
              out_item_d.last      = 1'b1;
              out_item_d.error     = 1'b1;
              out_item_d.length    = '0;
              state_d              = ST_IDLE;
            end
          end else begin
            total_d     = total;
            left_d      = total;
            sign_pend_d = neg_q;
            state_d     = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d.error = 1'b0;
          out_item_d.last  = (left_q == LEN_W'(1));
          out_item_d.length = (left_q == LEN_W'(1)) ? total_q : '0;
          if (sign_pend_q) begin
            out_item_d.character = ASCII_MINUS;
            sign_pend_d          = 1'b0;
          end else begin
            out_item_d.character = ASCII_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            pop                  = 1'b1;
          end
          left_d = left_q - 1'b1;
          if (left_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      sign_pend_q <= 1'b0;
      total_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      sign_pend_q <= sign_pend_d;
      total_q     <= total_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    cap_q      <= cap_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `I2DT_ASSERT_SAME(a_error_is_last, clk_i, rst_ni, out_valid_o && out_item_o.error,
      out_item_o.last && out_item_o.length == '0 && out_item_o.character == CHAR_NONE)
  `I2DT_ASSERT_SAME(a_len_only_on_last, clk_i, rst_ni,
      out_valid_o && !out_item_o.last, out_item_o.length == '0)
  `I2DT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  `I2DT_ASSERT_SAME(a_emit_left_nonzero, clk_i, rst_ni, state_q == ST_EMIT,
      left_q != '0)

endmodule
